// ===== rtl/stack_machine_execute_core_defines.svh =====
// Assertion macros shared by the stack machine execute core.
// Expects clk and rst_n in the scope of each use; no other dependencies.
`ifndef STACK_MACHINE_EXECUTE_CORE_DEFINES_SVH
`define STACK_MACHINE_EXECUTE_CORE_DEFINES_SVH

// Check a condition in the same cycle as its trigger
`define SMX_ASSERT_NOW(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Check a condition in the cycle after its trigger
`define SMX_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== rtl/smx_pkg.sv =====
// Shared types, codes and defaults for the stack machine execute core.
// No dependencies; imported by every module of the block.
package smx_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int REG_COUNT_DEF   = 16;
    localparam int WORD_BYTES_DEF  = 8;
    localparam int WORD_W          = 64;
    localparam int IP_W            = 32;
    localparam int CMD_W           = 5;

    typedef enum logic [CMD_W-1:0] {
        OP_PUSH   = 5'd0,
        OP_GOTO   = 5'd1,
        OP_JZ     = 5'd2,
        OP_JNZ    = 5'd3,
        OP_ADD    = 5'd4,
        OP_SUB    = 5'd5,
        OP_DUP    = 5'd6,
        OP_DROP   = 5'd7,
        OP_PUTREG = 5'd8,
        OP_GETREG = 5'd9,
        OP_CMP3   = 5'd10,
        OP_EQ     = 5'd11,
        OP_NE     = 5'd12,
        OP_GT     = 5'd13,
        OP_LT     = 5'd14,
        OP_GE     = 5'd15,
        OP_LE     = 5'd16
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_UNDER  = 2'd1,
        ST_OVER   = 2'd2,
        ST_BADREG = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        MV_HOLD = 2'd0,
        MV_PUSH = 2'd1,
        MV_POP  = 2'd2
    } stk_move_t;

    // Outcome of one instruction, from the execute logic to the state registers
    typedef struct packed {
        status_t           status;
        stk_move_t         move;
        logic              rf_we;
        logic [IP_W-1:0]   ip_next;
        logic [WORD_W-1:0] top_next;
    } exec_res_t;

endpackage

// ===== rtl/stack_machine_execute_core.sv =====
// Stack machine execute core: one instruction per item on the cmd channel,
// one result item per instruction on the res channel.
// cmd channel: command (opcode) and immediate, valid/ready.
// res channel: status, next_ip, stack_count, top_value, valid/ready.
// An accepted item is held in the input register and executed while the
// output register is empty or being read. Its result is then loaded into the
// output register, which drives res_valid. Throughput is one item per cycle
// while the receiver does not stall; the two top stack entries are held in
// registers and the third is prefetched from the spill memory, so no opcode
// has to wait on a memory read.
// When the receiver stalls, the result is held and the input register keeps
// one further item; cmd_ready drops once both are full.
// Reset empties the stack, zeroes the instruction pointer and clears the
// register file at once; no clearing pass is needed.
// Depends on smx_pkg, smx_exec, smx_spill_ram and the defines header.
`include "stack_machine_execute_core_defines.svh"

module stack_machine_execute_core #(
    parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF,
    parameter int REG_COUNT   = smx_pkg::REG_COUNT_DEF,
    parameter int WORD_BYTES  = smx_pkg::WORD_BYTES_DEF,
    localparam int SP_W       = $clog2(STACK_DEPTH + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    output logic                       cmd_ready,
    input  logic [smx_pkg::CMD_W-1:0]  command,
    input  logic [smx_pkg::WORD_W-1:0] immediate,
    output logic                       res_valid,
    input  logic                       res_ready,
    output logic [1:0]                 status,
    output logic [smx_pkg::IP_W-1:0]   next_ip,
    output logic [SP_W-1:0]            stack_count,
    output logic [smx_pkg::WORD_W-1:0] top_value
);
    import smx_pkg::*;

    localparam int MEM_DEPTH = (STACK_DEPTH > 2) ? (STACK_DEPTH - 2) : 1;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int REG_W     = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    // Input register
    logic              in_valid_reg;
    logic [CMD_W-1:0]  cmd_reg;
    logic [WORD_W-1:0] imm_reg;

    // Architectural state
    logic [SP_W-1:0]   sp_reg;
    logic [SP_W-1:0]   sp_next;
    logic [IP_W-1:0]   ip_reg;
    logic [WORD_W-1:0] top_reg;
    logic [WORD_W-1:0] next_reg;
    logic [WORD_W-1:0] third;
    logic [WORD_W-1:0] rf_reg [REG_COUNT];
    logic [WORD_W-1:0] rf_rdata;
    logic [REG_W-1:0]  rf_idx;

    // Output register
    logic              res_valid_reg;
    status_t           status_reg;
    logic [IP_W-1:0]   next_ip_reg;
    logic [SP_W-1:0]   stack_count_reg;
    logic [WORD_W-1:0] top_value_reg;

    exec_res_t         exec_res;
    logic              exec_fire;
    logic              ok;
    logic [SP_W-1:0]   sp_m2;
    logic [SP_W-1:0]   sp_m3;
    logic              mem_wr_en;
    logic              mem_rd_en;

    // Handshake
    assign exec_fire = in_valid_reg && (!res_valid_reg || res_ready);
    assign cmd_ready = !in_valid_reg || exec_fire;
    assign ok        = (exec_res.status == ST_OK);

    // Capture an accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (cmd_ready)
        begin
            in_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
        begin
            cmd_reg <= command;
            imm_reg <= immediate;
        end
    end

    // Register file read
    assign rf_idx   = imm_reg[REG_W-1:0];
    assign rf_rdata = rf_reg[rf_idx];

    smx_exec #(
        .STACK_DEPTH (STACK_DEPTH),
        .REG_COUNT   (REG_COUNT),
        .WORD_BYTES  (WORD_BYTES),
        .SP_W        (SP_W)
    ) u_exec (
        .command   (cmd_reg),
        .immediate (imm_reg),
        .sp        (sp_reg),
        .ip        (ip_reg),
        .top       (top_reg),
        .next      (next_reg),
        .rf_rdata  (rf_rdata),
        .res       (exec_res)
    );

    // Next stack depth
    always_comb
    begin
        sp_next = sp_reg;
        if (exec_fire)
        begin
            case (exec_res.move)
                MV_PUSH: sp_next = sp_reg + SP_W'(1);
                MV_POP:  sp_next = sp_reg - SP_W'(1);
                default: sp_next = sp_reg;
            endcase
        end
    end

    // Spill the old next entry on a push; prefetch the entry under next
    assign sp_m2     = sp_reg - SP_W'(2);
    assign sp_m3     = sp_next - SP_W'(3);
    assign mem_wr_en = exec_fire && (exec_res.move == MV_PUSH) && (sp_reg >= SP_W'(2));
    assign mem_rd_en = (sp_next >= SP_W'(3));

    smx_spill_ram #(
        .DEPTH  (MEM_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_spill (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (sp_m2[ADDR_W-1:0]),
        .wr_data (next_reg),
        .rd_en   (mem_rd_en),
        .rd_addr (sp_m3[ADDR_W-1:0]),
        .rd_data (third)
    );

    // Control state: depth and instruction pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg <= '0;
            ip_reg <= '0;
        end
        else if (exec_fire)
        begin
            sp_reg <= sp_next;
            ip_reg <= exec_res.ip_next;
        end
    end

    // Cached top two entries
    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            top_reg <= exec_res.top_next;
            case (exec_res.move)
                MV_PUSH: next_reg <= top_reg;
                MV_POP:  next_reg <= third;
                default: next_reg <= next_reg;
            endcase
        end
    end

    // Register file: cleared at reset, written by putreg
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                rf_reg[i] <= '0;
            end
        end
        else if (exec_fire && ok && exec_res.rf_we)
        begin
            rf_reg[rf_idx] <= top_reg;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (exec_fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            status_reg      <= exec_res.status;
            next_ip_reg     <= exec_res.ip_next;
            stack_count_reg <= sp_next;
            top_value_reg   <= (sp_next == '0) ? '0 : exec_res.top_next;
        end
    end

    assign res_valid   = res_valid_reg;
    assign status      = status_reg;
    assign next_ip     = next_ip_reg;
    assign stack_count = stack_count_reg;
    assign top_value   = top_value_reg;

    // Checks
    `SMX_ASSERT_NOW(a_sp_bound, 1'b1, sp_reg <= SP_W'(STACK_DEPTH), "stack depth out of range")
    `SMX_ASSERT_NOW(a_count_tracks, res_valid_reg, stack_count_reg == sp_reg, "count differs from depth")
    `SMX_ASSERT_NEXT(a_fault_keeps, exec_fire && !ok, sp_reg == $past(sp_reg), "fault moved stack")
    `SMX_ASSERT_NEXT(a_fire_shows, exec_fire, res_valid_reg, "executed item has no result")

endmodule

// ===== rtl/smx_spill_ram.sv =====
// Spill memory for stack entries below the two cached top entries.
// Registered read with write-to-read bypass; uses smx_pkg for the word width.
module smx_spill_ram #(
    parameter int DEPTH  = 62,
    parameter int ADDR_W = 6
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic [smx_pkg::WORD_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [ADDR_W-1:0]         rd_addr,
    output logic [smx_pkg::WORD_W-1:0] rd_data
);
    import smx_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port: forward the word being written to the same address
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/smx_exec.sv =====
// Instruction decode and execute: status, pointer update, stack move, new top.
// Purely combinational; uses smx_pkg for opcodes, status codes and exec_res_t.
module smx_exec #(
    parameter int STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF,
    parameter int REG_COUNT   = smx_pkg::REG_COUNT_DEF,
    parameter int WORD_BYTES  = smx_pkg::WORD_BYTES_DEF,
    parameter int SP_W        = 7
) (
    input  logic [smx_pkg::CMD_W-1:0]  command,
    input  logic [smx_pkg::WORD_W-1:0] immediate,
    input  logic [SP_W-1:0]            sp,
    input  logic [smx_pkg::IP_W-1:0]   ip,
    input  logic [smx_pkg::WORD_W-1:0] top,
    input  logic [smx_pkg::WORD_W-1:0] next,
    input  logic [smx_pkg::WORD_W-1:0] rf_rdata,
    output smx_pkg::exec_res_t         res
);
    import smx_pkg::*;

    logic              sp_empty;
    logic              sp_lt2;
    logic              sp_full;
    logic              reg_ok;
    logic              top_gt;
    logic              top_eq;
    logic              is_zero;
    logic [IP_W-1:0]   ip_adv;
    logic [IP_W-1:0]   ip_tgt;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] diff;
    opcode_t           op;

    // Shared conditions and datapath
    assign sp_empty = (sp == '0);
    assign sp_lt2   = (sp < SP_W'(2));
    assign sp_full  = (sp == SP_W'(STACK_DEPTH));
    assign reg_ok   = (immediate < WORD_W'(REG_COUNT));
    assign top_gt   = ($signed(top) > $signed(next));
    assign top_eq   = (top == next);
    assign is_zero  = (top == '0);
    assign ip_adv   = ip + IP_W'(WORD_BYTES);
    assign ip_tgt   = immediate[IP_W-1:0];
    assign sum      = next + top;
    assign diff     = next - top;
    assign op       = opcode_t'(command);

    // Decode and execute one instruction
    always_comb
    begin
        res          = '0;
        res.status   = ST_OK;
        res.move     = MV_HOLD;
        res.rf_we    = 1'b0;
        res.ip_next  = ip;
        res.top_next = top;
        unique case (op) inside
            OP_PUSH:
            begin
                res.ip_next = ip_adv;
                if (sp_full)
                begin
                    res.status = ST_OVER;
                end
                else
                begin
                    res.move     = MV_PUSH;
                    res.top_next = immediate;
                end
            end
            OP_GOTO:
            begin
                res.ip_next = ip_tgt;
            end
            OP_JZ, OP_JNZ:
            begin
                if (sp_empty)
                begin
                    res.status = ST_UNDER;
                end
                else
                begin
                    res.move     = MV_POP;
                    res.top_next = next;
                    res.ip_next  = (is_zero == (op == OP_JZ)) ? ip_tgt : ip_adv;
                end
            end
            OP_ADD, OP_SUB:
            begin
                if (sp_lt2)
                begin
                    res.status = ST_UNDER;
                end
                else
                begin
                    res.move     = MV_POP;
                    res.top_next = (op == OP_ADD) ? sum : diff;
                end
            end
            OP_DUP:
            begin
                if (sp_empty)
                begin
                    res.status = ST_UNDER;
                end
                else if (sp_full)
                begin
                    res.status = ST_OVER;
                end
                else
                begin
                    res.move = MV_PUSH;
                end
            end
            OP_DROP:
            begin
                if (sp_empty)
                begin
                    res.status = ST_UNDER;
                end
                else
                begin
                    res.move     = MV_POP;
                    res.top_next = next;
                end
            end
            OP_PUTREG:
            begin
                res.ip_next = ip_adv;
                if (sp_empty)
                begin
                    res.status = ST_UNDER;
                end
                else if (!reg_ok)
                begin
                    res.status = ST_BADREG;
                end
                else
                begin
                    res.move     = MV_POP;
                    res.rf_we    = 1'b1;
                    res.top_next = next;
                end
            end
            OP_GETREG:
            begin
                res.ip_next = ip_adv;
                if (!reg_ok)
                begin
                    res.status = ST_BADREG;
                end
                else if (sp_full)
                begin
                    res.status = ST_OVER;
                end
                else
                begin
                    res.move     = MV_PUSH;
                    res.top_next = rf_rdata;
                end
            end
            OP_CMP3, OP_EQ, OP_NE, OP_GT, OP_LT, OP_GE, OP_LE:
            begin
                if (sp_lt2)
                begin
                    res.status = ST_UNDER;
                end
                else
                begin
                    res.move = MV_POP;
                    case (op)
                        OP_CMP3: res.top_next = top_gt ? WORD_W'(1)
                                              : (top_eq ? '0 : '1);
                        OP_EQ:   res.top_next = WORD_W'(top_eq);
                        OP_NE:   res.top_next = WORD_W'(!top_eq);
                        OP_GT:   res.top_next = WORD_W'(top_gt);
                        OP_LT:   res.top_next = WORD_W'(!top_gt && !top_eq);
                        OP_GE:   res.top_next = WORD_W'(top_gt || top_eq);
                        default: res.top_next = WORD_W'(!top_gt);
                    endcase
                end
            end
            default:
            begin
                // unused opcode: no effect
                res.status = ST_OK;
            end
        endcase
    end

endmodule

// ===== tb/stack_machine_execute_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for stack_machine_execute_core: random and directed
// instruction streams checked against an in-bench model of the stack machine.
// Depends on smx_pkg and the core RTL only.
module stack_machine_execute_core_tb;
    import smx_pkg::*;

    localparam int STACK_DEPTH = STACK_DEPTH_DEF;
    localparam int REG_COUNT   = REG_COUNT_DEF;
    localparam int WORD_BYTES  = WORD_BYTES_DEF;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int REG_IDX_W   = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int ITEM_COUNT  = 1000;

    typedef enum int {TILT_EVEN, TILT_FILL, TILT_DRAIN} tilt_t;

    typedef struct {
        status_t           status;
        logic [IP_W-1:0]   next_ip;
        logic [SP_W-1:0]   stack_count;
        logic [WORD_W-1:0] top_value;
    } step_result_t;

    // Model of the machine state plus the queue of results still owed
    class smx_scoreboard;
        logic [WORD_W-1:0] stack_mem [STACK_DEPTH];
        logic [WORD_W-1:0] regs [REG_COUNT];
        int                depth;
        logic [IP_W-1:0]   ip;
        step_result_t      pending_results [$];
        int                errors;

        function new();
            foreach (stack_mem[i]) stack_mem[i] = '0;
            foreach (regs[i]) regs[i] = '0;
            depth  = 0;
            ip     = '0;
            errors = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Execute one accepted instruction and queue the result it must give
        function void note_command(logic [CMD_W-1:0] cmd, logic [WORD_W-1:0] imm);
            status_t                  st;
            logic                     reg_ok;
            logic                     is_zero;
            logic signed [WORD_W-1:0] top_s;
            logic signed [WORD_W-1:0] nxt_s;
            logic [WORD_W-1:0]        r;
            step_result_t             res;
            st     = ST_OK;
            reg_ok = !imm[WORD_W-1] && (imm < REG_COUNT);
            case (cmd)
                OP_PUSH: begin
                    ip = ip + IP_W'(WORD_BYTES);
                    if (depth >= STACK_DEPTH) st = ST_OVER;
                    else begin
                        stack_mem[depth] = imm;
                        depth++;
                    end
                end
                OP_GOTO: ip = imm[IP_W-1:0];
                OP_JZ, OP_JNZ: begin
                    // an underflowing jump leaves the pointer where it is
                    if (depth < 1) st = ST_UNDER;
                    else begin
                        is_zero = (stack_mem[depth-1] == '0);
                        depth--;
                        if (is_zero == (cmd == OP_JZ)) ip = imm[IP_W-1:0];
                        else ip = ip + IP_W'(WORD_BYTES);
                    end
                end
                OP_ADD, OP_SUB: begin
                    if (depth < 2) st = ST_UNDER;
                    else begin
                        if (cmd == OP_ADD)
                            stack_mem[depth-2] = stack_mem[depth-2] + stack_mem[depth-1];
                        else
                            stack_mem[depth-2] = stack_mem[depth-2] - stack_mem[depth-1];
                        depth--;
                    end
                end
                OP_DUP: begin
                    if (depth < 1) st = ST_UNDER;
                    else if (depth >= STACK_DEPTH) st = ST_OVER;
                    else begin
                        stack_mem[depth] = stack_mem[depth-1];
                        depth++;
                    end
                end
                OP_DROP: begin
                    if (depth < 1) st = ST_UNDER;
                    else depth--;
                end
                OP_PUTREG: begin
                    // underflow takes priority over a bad index
                    ip = ip + IP_W'(WORD_BYTES);
                    if (depth < 1) st = ST_UNDER;
                    else if (!reg_ok) st = ST_BADREG;
                    else begin
                        regs[imm[REG_IDX_W-1:0]] = stack_mem[depth-1];
                        depth--;
                    end
                end
                OP_GETREG: begin
                    // a bad index takes priority over overflow
                    ip = ip + IP_W'(WORD_BYTES);
                    if (!reg_ok) st = ST_BADREG;
                    else if (depth >= STACK_DEPTH) st = ST_OVER;
                    else begin
                        stack_mem[depth] = regs[imm[REG_IDX_W-1:0]];
                        depth++;
                    end
                end
                OP_CMP3, OP_EQ, OP_NE, OP_GT, OP_LT, OP_GE, OP_LE: begin
                    // an underflowing compare reports the fault and pushes nothing
                    if (depth < 2) st = ST_UNDER;
                    else begin
                        top_s = stack_mem[depth-1];
                        nxt_s = stack_mem[depth-2];
                        case (cmd)
                            OP_CMP3: r = (top_s > nxt_s) ? 64'd1 :
                                         (top_s == nxt_s) ? 64'd0 : {WORD_W{1'b1}};
                            OP_EQ:   r = {63'd0, top_s == nxt_s};
                            OP_NE:   r = {63'd0, top_s != nxt_s};
                            OP_GT:   r = {63'd0, top_s > nxt_s};
                            OP_LT:   r = {63'd0, top_s < nxt_s};
                            OP_GE:   r = {63'd0, top_s >= nxt_s};
                            default: r = {63'd0, top_s <= nxt_s};
                        endcase
                        stack_mem[depth-2] = r;
                        depth--;
                    end
                end
                default: ; // unused opcodes do nothing
            endcase
            res.status      = st;
            res.next_ip     = ip;
            res.stack_count = SP_W'(depth);
            res.top_value   = (depth > 0) ? stack_mem[depth-1] : '0;
            pending_results.push_back(res);
        endfunction

        function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t: %s expected %h, got %h", $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        // Check one accepted result against the oldest owed result
        function void check_result(logic [1:0] st, logic [IP_W-1:0] nip,
                                   logic [SP_W-1:0] cnt, logic [WORD_W-1:0] top);
            step_result_t owed;
            if (pending_results.size() == 0) begin
                $display("%0t: result with none owed: status %h ip %h count %0d top %h",
                         $time, st, nip, cnt, top);
                errors++;
                return;
            end
            owed = pending_results.pop_front();
            compare_field("status", 64'(owed.status), 64'(st));
            compare_field("next_ip", 64'(owed.next_ip), 64'(nip));
            compare_field("stack_count", 64'(owed.stack_count), 64'(cnt));
            compare_field("top_value", owed.top_value, top);
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                cmd_valid;
    logic                cmd_ready;
    logic [CMD_W-1:0]    command;
    logic [WORD_W-1:0]   immediate;
    logic                res_valid;
    logic                res_ready;
    logic [1:0]          status;
    logic [IP_W-1:0]     next_ip;
    logic [SP_W-1:0]     stack_count;
    logic [WORD_W-1:0]   top_value;

    smx_scoreboard sb = new();
    bit            send_quiet;

    stack_machine_execute_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .command     (command),
        .immediate   (immediate),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .status      (status),
        .next_ip     (next_ip),
        .stack_count (stack_count),
        .top_value   (top_value)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on run time
    initial begin
        #2_000_000;
        $display("stack_machine_execute_core: mismatch");
        $finish;
    end

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Offer one item after a random gap and hold it until accepted
    task automatic offer(input logic [CMD_W-1:0] cmd, input logic [WORD_W-1:0] imm);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        command   <= cmd;
        immediate <= imm;
        do @(posedge clk); while (!cmd_ready);
        sb.note_command(cmd, imm);
    endtask

    function automatic logic [CMD_W-1:0] pick_command(tilt_t tilt);
        int k;
        k = $urandom_range(0, 99);
        if (k < 4) return CMD_W'($urandom_range(OP_LE + 1, 31));
        if (tilt == TILT_FILL && k < 90) begin
            case ($urandom_range(0, 3))
                0, 1:    return OP_PUSH;
                2:       return OP_GETREG;
                default: return OP_DUP;
            endcase
        end
        if (tilt == TILT_DRAIN && k < 60) begin
            case ($urandom_range(0, 6))
                0:       return OP_DROP;
                1:       return OP_ADD;
                2:       return OP_SUB;
                3:       return OP_JZ;
                4:       return OP_JNZ;
                5:       return OP_PUTREG;
                default: return CMD_W'($urandom_range(OP_CMP3, OP_LE));
            endcase
        end
        return CMD_W'($urandom_range(OP_PUSH, OP_LE));
    endfunction

    function automatic logic [WORD_W-1:0] pick_immediate(logic [CMD_W-1:0] cmd);
        case (cmd)
            OP_PUSH: begin
                // favour small values so that compares see equal operands
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: return WORD_W'($urandom_range(0, 3));
                    4:          return -WORD_W'($urandom_range(1, 3));
                    5:          return {1'b0, {(WORD_W-1){1'b1}}};
                    6:          return {1'b1, {(WORD_W-1){1'b0}}};
                    default:    return rand_word();
                endcase
            end
            OP_PUTREG, OP_GETREG: begin
                if ($urandom_range(0, 9) < 8) return WORD_W'($urandom_range(0, REG_COUNT - 1));
                if ($urandom_range(0, 1) == 0) return WORD_W'(REG_COUNT + $urandom_range(0, 3));
                return rand_word();
            end
            default: return rand_word();
        endcase
    endfunction

    // Short directed sequence over faults, extremes and pointer wrap
    task automatic run_directed();
        offer(OP_DROP,   '0);
        offer(OP_JZ,     64'h0000_0000_0000_0040);
        offer(OP_ADD,    '0);
        offer(OP_CMP3,   '0);
        offer(OP_PUTREG, '0);
        offer(OP_GETREG, {WORD_W{1'b1}});
        offer(OP_GETREG, 64'(REG_COUNT));
        offer(OP_GETREG, 64'(REG_COUNT - 1));
        offer(OP_PUSH,   64'h7FFF_FFFF_FFFF_FFFF);
        offer(OP_PUSH,   64'd1);
        offer(OP_ADD,    '0);
        offer(OP_PUSH,   64'h8000_0000_0000_0000);
        offer(OP_EQ,     '0);
        offer(OP_DUP,    '0);
        offer(OP_SUB,    '0);
        offer(OP_JZ,     64'hDEAD_BEEF_0000_1234);
        offer(OP_PUSH,   -64'sd5);
        offer(OP_PUSH,   64'd3);
        offer(OP_CMP3,   '0);
        offer(OP_JNZ,    64'h0000_0000_FFFF_FFF8);
        offer(OP_PUSH,   '0);
        offer(OP_JNZ,    64'h0000_0000_0000_0100);
        offer(OP_PUSH,   64'd7);
        offer(OP_PUTREG, 64'h8000_0000_0000_0003);
        offer(OP_PUTREG, 64'd3);
        offer(5'd31,     rand_word());
        offer(OP_GOTO,   64'hFFFF_FFFF_8000_0000);
    endtask

    // Receiver: random stalls, one long hold-off, check every result
    initial begin
        int stall;
        int seen;
        bit quiet;
        seen  = 0;
        quiet = 1'b0;
        res_ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever begin
            if (seen % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
            stall = quiet ? 0 : $urandom_range(0, 8);
            if (seen == 300) stall = 80;
            if (stall > 0) begin
                res_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ready <= 1'b1;
            do @(posedge clk); while (!res_valid);
            sb.check_result(status, next_ip, stack_count, top_value);
            seen++;
        end
    end

    // Sender: reset, directed items, then random stretches of instructions
    initial begin
        tilt_t            tilt;
        logic [CMD_W-1:0] cmd;
        rst_n      <= 1'b0;
        cmd_valid  <= 1'b0;
        command    <= '0;
        immediate  <= '0;
        send_quiet = 1'b0;
        tilt       = TILT_FILL;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        for (int i = 0; i < ITEM_COUNT; i++) begin
            if (i % 80 == 0) begin
                tilt       = (i == 0) ? TILT_FILL : tilt_t'($urandom_range(0, 2));
                send_quiet = ($urandom_range(0, 3) == 0);
            end
            // let the block drain completely once
            if (i == 500) begin
                cmd_valid <= 1'b0;
                do @(posedge clk); while (sb.pending() != 0);
            end
            cmd = pick_command(tilt);
            offer(cmd, pick_immediate(cmd));
        end
        cmd_valid <= 1'b0;

        do @(posedge clk); while (sb.pending() != 0);
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("stack_machine_execute_core: match");
        else
            $display("stack_machine_execute_core: mismatch");
        $finish;
    end

endmodule
